FILE: design/plc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plc_pkg: shared types and constants for the price level order queue
// Operation and status codes, fixed field widths and the per-cell command.
// ----------------------------------------------------------------------------
package plc_pkg;

    localparam int VOL_W  = 40;
    localparam int SIZE_W = 32;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_REMOVE = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_ABSENT = 2'd1,
        ST_BUSY   = 2'd2
    } status_t;

    // Broadcast to every queue cell in the commit cycle
    typedef struct packed {
        logic append;
        logic remove;
        logic clear;
    } cell_cmd_t;

endpackage

FILE: design/plc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plc_cell: one position of the order queue
// Holds the slot queued at this position; loads on append at the fill point,
// takes the right neighbor's entry when a removal opens a gap at or before it.
// ----------------------------------------------------------------------------
module plc_cell #(
    parameter int SLOT_W = 8,
    parameter int CNT_W  = 9,
    parameter int INDEX  = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  plc_pkg::cell_cmd_t  cmd,
    input  logic [SLOT_W-1:0]   target_slot,
    input  logic [CNT_W-1:0]    fill_count,
    input  logic                shift_hit,
    input  logic                right_valid,
    input  logic [SLOT_W-1:0]   right_slot,
    output logic                valid,
    output logic [SLOT_W-1:0]   slot,
    output logic                match
);

    logic              valid_reg;
    logic [SLOT_W-1:0] slot_reg;

    assign valid = valid_reg;
    assign slot  = slot_reg;
    assign match = valid_reg && (slot_reg == target_slot);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            slot_reg  <= '0;
        end
        else if (cmd.clear)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd.append && (fill_count == CNT_W'(INDEX)))
        begin
            valid_reg <= 1'b1;
            slot_reg  <= target_slot;
        end
        else if (cmd.remove && shift_hit)
        begin
            // advance the right neighbor's entry into this position
            valid_reg <= right_valid;
            slot_reg  <= right_slot;
        end
    end

endmodule

FILE: design/plc_prefix_or.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plc_prefix_or: parallel prefix OR over the cell match flags
// Bit k of the output is set when any cell at or before position k matches.
// ----------------------------------------------------------------------------
module plc_prefix_or #(
    parameter int N = 256
) (
    input  logic [N-1:0] hit_in,
    output logic [N-1:0] hit_prefix
);

    localparam int LEVELS = $clog2(N);

    logic [N-1:0] stage [0:LEVELS];

    always_comb
    begin
        stage[0] = hit_in;
        for (int l = 0; l < LEVELS; l++)
        begin
            for (int i = 0; i < N; i++)
            begin
                if (i >= (1 << l))
                    stage[l+1][i] = stage[l][i] | stage[l][i - (1 << l)];
                else
                    stage[l+1][i] = stage[l][i];
            end
        end
    end

    assign hit_prefix = stage[LEVELS];

endmodule

FILE: design/price_level_order_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// price_level_order_queue_top: one price level of an order book
// Time-priority queue of order slots held in a row of cells, with per-slot
// queued marks and sizes, total volume and order count.
// ----------------------------------------------------------------------------
// Sequence: an accepted item is captured into the op, slot and size
//   registers and busy is raised for its commit; done is registered from
//   busy and rises as the committed level state appears.
// Handshake: start is taken only while busy is low, so a new item waits
//   until the previous one commits; the target size is read at accept.
// Reset: clears the queue cells, queued marks, volume and count at once; no
//   clearing pass. The result side cannot stall.
// ----------------------------------------------------------------------------
module price_level_order_queue_top #(
    parameter int SLOTS     = 256,
    parameter int SIZE_BITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      op,
    input  logic [$clog2(SLOTS)-1:0]        order_slot,
    input  logic [plc_pkg::SIZE_W-1:0]      order_size,
    output logic                            done,
    output logic [1:0]                      status,
    output logic [plc_pkg::VOL_W-1:0]       level_volume,
    output logic [$clog2(SLOTS+1)-1:0]      order_count,
    output logic                            level_empty,
    output logic [$clog2(SLOTS)-1:0]        front_slot
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS+1);
    localparam int VOL_W  = plc_pkg::VOL_W;
    localparam logic [63:0] SIZE_MASK =
        (SIZE_BITS >= 64) ? {64{1'b1}} : ((64'd1 << SIZE_BITS) - 64'd1);

    // ------------------------------------------------------------------
    // Handshake and captured item
    // ------------------------------------------------------------------
    logic                    accept;
    logic                    busy_reg;
    plc_pkg::op_t            op_reg;
    logic [SLOT_W-1:0]       slot_reg;
    logic [plc_pkg::SIZE_W-1:0] size_reg;

    // ------------------------------------------------------------------
    // Level state
    // ------------------------------------------------------------------
    logic [SIZE_BITS-1:0]    qty_mem [0:SLOTS-1];
    logic [SIZE_BITS-1:0]    qty_rd_reg;
    logic [SLOTS-1:0]        queued_reg;
    logic [VOL_W-1:0]        volume_reg;
    logic [CNT_W-1:0]        count_reg;
    logic                    done_reg;
    plc_pkg::status_t        status_reg;
    plc_pkg::status_t        status_next;

    // ------------------------------------------------------------------
    // Commit-cycle decode
    // ------------------------------------------------------------------
    logic                    slot_in_range;
    logic                    slot_queued;
    logic                    do_append;
    logic                    do_remove;
    logic                    do_clear;
    logic [63:0]             size_ext;
    logic [SIZE_BITS-1:0]    size_kept;
    logic [63:0]             qty_ext;
    plc_pkg::cell_cmd_t      cell_cmd;

    // ------------------------------------------------------------------
    // Cell row: position 0 is the head; entries stay packed from the left
    // ------------------------------------------------------------------
    logic [SLOTS:0]          chain_valid;
    logic [SLOT_W-1:0]       chain_slot [0:SLOTS];
    logic [SLOTS-1:0]        cell_match;
    logic [SLOTS-1:0]        shift_hit;

    assign accept = start && !busy_reg;
    assign busy   = busy_reg;

    // Slots at or above SLOTS are never queued
    assign slot_in_range = ({1'b0, slot_reg} < (SLOT_W+1)'(SLOTS));
    assign slot_queued   = slot_in_range && queued_reg[slot_reg];

    assign do_append = busy_reg && (op_reg == plc_pkg::OP_APPEND) && slot_in_range
                       && !slot_queued;
    assign do_remove = busy_reg && (op_reg == plc_pkg::OP_REMOVE) && slot_queued;
    assign do_clear  = busy_reg && (op_reg == plc_pkg::OP_CLEAR);

    // Keep only the low SIZE_BITS of the order size
    assign size_ext  = {{(64-plc_pkg::SIZE_W){1'b0}}, size_reg} & SIZE_MASK;
    assign size_kept = size_ext[SIZE_BITS-1:0];
    assign qty_ext   = 64'(qty_rd_reg);

    assign cell_cmd.append = do_append;
    assign cell_cmd.remove = do_remove;
    assign cell_cmd.clear  = do_clear;

    always_comb
    begin
        case (op_reg)
            plc_pkg::OP_APPEND:
                status_next = (slot_in_range && !slot_queued) ? plc_pkg::ST_DONE
                                                              : plc_pkg::ST_BUSY;
            plc_pkg::OP_REMOVE:
                status_next = slot_queued ? plc_pkg::ST_DONE : plc_pkg::ST_ABSENT;
            default:
                status_next = plc_pkg::ST_DONE;
        endcase
    end

    // Capture the item on transfer; the commit follows in the next cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            op_reg     <= plc_pkg::OP_NOP;
            slot_reg   <= '0;
            size_reg   <= '0;
            done_reg   <= 1'b0;
            status_reg <= plc_pkg::ST_DONE;
        end
        else
        begin
            busy_reg <= accept;
            done_reg <= busy_reg;
            if (accept)
            begin
                op_reg   <= plc_pkg::op_t'(op);
                slot_reg <= order_slot;
                size_reg <= order_size;
            end
            if (busy_reg)
                status_reg <= status_next;
        end
    end

    // Size memory: read the target slot at transfer, write it on append
    always_ff @(posedge clk)
    begin
        if (accept)
            qty_rd_reg <= qty_mem[order_slot];
        if (do_append)
            qty_mem[slot_reg] <= size_kept;
    end

    // Queued marks, volume and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            queued_reg <= '0;
            volume_reg <= '0;
            count_reg  <= '0;
        end
        else if (do_clear)
        begin
            queued_reg <= '0;
            volume_reg <= '0;
            count_reg  <= '0;
        end
        else if (do_append)
        begin
            queued_reg[slot_reg] <= 1'b1;
            volume_reg <= volume_reg + VOL_W'(size_ext);
            count_reg  <= count_reg + CNT_W'(1);
        end
        else if (do_remove)
        begin
            queued_reg[slot_reg] <= 1'b0;
            volume_reg <= volume_reg - VOL_W'(qty_ext);
            count_reg  <= count_reg - CNT_W'(1);
        end
    end

    // Past the last cell the row reads as empty
    assign chain_valid[SLOTS] = 1'b0;
    assign chain_slot[SLOTS]  = '0;

    // Every cell at or right of the removed entry shifts left by one
    plc_prefix_or #(
        .N (SLOTS)
    ) u_prefix (
        .hit_in     (cell_match),
        .hit_prefix (shift_hit)
    );

    for (genvar k = 0; k < SLOTS; k++)
    begin : g_cell
        plc_cell #(
            .SLOT_W (SLOT_W),
            .CNT_W  (CNT_W),
            .INDEX  (k)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cell_cmd),
            .target_slot (slot_reg),
            .fill_count  (count_reg),
            .shift_hit   (shift_hit[k]),
            .right_valid (chain_valid[k+1]),
            .right_slot  (chain_slot[k+1]),
            .valid       (chain_valid[k]),
            .slot        (chain_slot[k]),
            .match       (cell_match[k])
        );
    end

    // Result: strobe for one cycle; level fields come straight from state,
    // which holds until the next commit
    assign done         = done_reg;
    assign status       = status_reg;
    assign level_volume = volume_reg;
    assign order_count  = count_reg;
    assign level_empty  = (count_reg == '0);
    assign front_slot   = (count_reg == '0) ? '0 : chain_slot[0];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_head_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        chain_valid[0] == (count_reg != '0))
        else $error("head cell occupancy disagrees with order count");

    a_remove_one_match: assert property (@(posedge clk) disable iff (!rst_n)
        do_remove |-> $onehot(cell_match))
        else $error("removal must find exactly one queue cell");

    a_append_no_match: assert property (@(posedge clk) disable iff (!rst_n)
        do_append |-> (cell_match == '0))
        else $error("appended slot already present in the queue cells");

    a_empty_zero_volume: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (volume_reg == '0))
        else $error("empty level with nonzero volume");

    a_single_commit: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |=> (!busy_reg && done_reg))
        else $error("commit cycle not followed by a result strobe");

endmodule
